@@ hdl/fcc_pkg.sv @@
package fcc_pkg;

    localparam int          FCC_FRAME_BYTES   = 16;
    localparam int          FCC_COVERED_BYTES = 14;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] byte_index;
        logic       frame_end;
        logic       crc_ok;
    } t_result;

endpackage

@@ hdl/fcc_in_if.sv @@
interface fcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ hdl/fcc_out_if.sv @@
interface fcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [3:0] byte_index;
    logic       frame_end;
    logic       crc_ok;

    modport source (output valid, output byte_out, output byte_index, output frame_end,
                    output crc_ok, input ready);
    modport sink   (input valid, input byte_out, input byte_index, input frame_end,
                    input crc_ok, output ready);
endinterface

@@ hdl/fcc_crc8.sv @@
module fcc_crc8 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);
    import fcc_pkg::*;

    // one byte, MSB first, unrolled over the eight bit steps
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end
endmodule

@@ hdl/fcc_frame_track.sv @@
module fcc_frame_track #(
    parameter int FRAME_BYTES   = 16,
    parameter int COVERED_BYTES = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_start,
    output fcc_pkg::t_result o_result
);
    import fcc_pkg::*;

    localparam int PW      = $clog2(FRAME_BYTES);
    localparam int CRC_END = (COVERED_BYTES < FRAME_BYTES - 2) ? COVERED_BYTES
                                                               : FRAME_BYTES - 2;
    localparam logic [PW-1:0] LAST_P   = PW'(FRAME_BYTES - 1);
    localparam logic [PW-1:0] HI_P     = PW'(FRAME_BYTES - 2);
    localparam logic [PW-1:0] CRC_ENDP = PW'(CRC_END);

    logic [PW-1:0] r_position, n_position;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_trailer_high, n_trailer_high;

    logic [PW-1:0] p;
    logic [PW+3:0] p_ext;
    logic [15:0]   crc_base;
    logic [15:0]   crc_upd;
    logic          is_last;

    assign p        = i_frame_start ? '0 : r_position;
    assign p_ext    = {4'b0000, p};
    assign crc_base = (p == '0) ? CRC_INIT : r_crc;
    assign is_last  = (p == LAST_P);

    fcc_crc8 u_crc8 (
        .i_crc  (crc_base),
        .i_data (i_data_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        n_position     = is_last ? '0 : p + PW'(1);
        n_trailer_high = (p == HI_P) ? i_data_byte : r_trailer_high;
        if (is_last) begin
            n_crc = CRC_INIT;
        end else if (p < CRC_ENDP) begin
            n_crc = crc_upd;
        end else begin
            n_crc = crc_base;
        end

        o_result.byte_out   = i_data_byte;
        o_result.byte_index = p_ext[3:0];
        o_result.frame_end  = is_last;
        o_result.crc_ok     = is_last && ({r_trailer_high, i_data_byte} == crc_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= '0;
            r_crc          <= CRC_INIT;
            r_trailer_high <= 8'h00;
        end else if (i_step) begin
            r_position     <= n_position;
            r_crc          <= n_crc;
            r_trailer_high <= n_trailer_high;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= LAST_P)
        else $error("position out of frame");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.frame_end |=> r_position == '0 && r_crc == CRC_INIT)
        else $error("no wrap after last byte");

    a_ok_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.crc_ok |-> o_result.frame_end)
        else $error("crc_ok outside frame end");

    a_start_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_start |-> o_result.byte_index == 4'd0)
        else $error("frame start not at index 0");
endmodule

@@ hdl/frame_crc_checker.sv @@
// Frame CRC checker for a fixed-length byte frame.
// i_in carries one received byte per beat (data_byte, frame_start). o_out returns one
// beat per input beat: the byte echoed, its index in the frame, frame_end on the last
// trailer byte and crc_ok, which is set on that beat when the two trailer bytes (high
// first) equal the CRC-16/CCITT-FALSE of the covered bytes.
// frame_start forces the beat to index 0 and restarts the CRC; after the last byte the
// count wraps, so frames may follow with no frame_start.
// Path: an accepted beat sits in the input register, then passes the CRC update into
// the result register, which offers it on o_out until the receiver takes it.
// Throughput: one beat per cycle while the receiver does not stall; the byte-wide CRC
// update is a single unrolled step between the input and result registers.
// Reset clears the frame position, reloads the CRC seed and empties both registers.
// When the receiver stalls, the result register holds, the input register keeps one
// more beat, and i_in.ready drops only when both are full.
module frame_crc_checker #(
    parameter int FRAME_BYTES   = fcc_pkg::FCC_FRAME_BYTES,
    parameter int COVERED_BYTES = fcc_pkg::FCC_COVERED_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fcc_in_if.sink    i_in,
    fcc_out_if.source o_out
);
    import fcc_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_data;
    logic       r_s1_start;
    logic       r_o_valid;
    t_result    r_o_result;
    t_result    result;
    logic       out_free;
    logic       s1_move;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    fcc_frame_track #(
        .FRAME_BYTES   (FRAME_BYTES),
        .COVERED_BYTES (COVERED_BYTES)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (s1_move),
        .i_data_byte   (r_s1_data),
        .i_frame_start (r_s1_start),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_data  <= i_in.data_byte;
            r_s1_start <= i_in.frame_start;
        end
        if (s1_move) begin
            r_o_result <= result;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.byte_out   = r_o_result.byte_out;
    assign o_out.byte_index = r_o_result.byte_index;
    assign o_out.frame_end  = r_o_result.frame_end;
    assign o_out.crc_ok     = r_o_result.crc_ok;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !o_out.ready |=> r_o_valid && $stable(r_o_result))
        else $error("stalled result changed");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_valid && r_o_valid && !o_out.ready)
        else $error("ready low with room");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_o_valid)
        else $error("beat lost between stages");
endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcc_pkg::*;

    localparam int FRAME = FCC_FRAME_BYTES;
    localparam int COVER = FCC_COVERED_BYTES;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } t_rx_beat;

    logic i_clk;
    logic i_rst_n;

    fcc_in_if  in_if();
    fcc_out_if out_if();

    frame_crc_checker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_rx_beat rx_bytes[$];   // bytes waiting to be offered
    t_result  echo_due[$];   // predicted echoes, oldest first

    // predictor state
    int          frame_pos  = 0;
    logic [15:0] crc_run    = CRC_INIT;
    logic [7:0]  trailer_hi = 8'h00;

    int  gap_pct   = 0;
    int  stall_pct = 0;
    bit  rx_hold   = 1'b0;
    bit  in_taken  = 1'b0;
    bit  need_sof  = 1'b0;

    int errors       = 0;
    int beats_seen   = 0;
    int frames_good  = 0;
    int frames_bad   = 0;
    int items_queued = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic t_result predict_echo(input logic [7:0] b, input logic sof);
        int      p;
        t_result r;
        p = sof ? 0 : frame_pos;
        if (p >= FRAME) p = 0;
        if (p == 0) crc_run = CRC_INIT;
        if (p < COVER && p < FRAME - 2) crc_run = crc16_step(crc_run, b);
        if (p == FRAME - 2) trailer_hi = b;
        r.byte_out   = b;
        r.byte_index = p[3:0];
        r.frame_end  = 1'b0;
        r.crc_ok     = 1'b0;
        if (p == FRAME - 1) begin
            r.frame_end = 1'b1;
            r.crc_ok    = ({trailer_hi, b} == crc_run);
            frame_pos   = 0;
            crc_run     = CRC_INIT;
        end else begin
            frame_pos = p + 1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // builds a frame with a valid trailer, optionally damaged, and queues its first len bytes
    task automatic queue_frame(input int len, input bit sof, input bit corrupt);
        logic [7:0]  fb [FRAME];
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME - 2; i++) begin
            fb[i] = 8'($urandom_range(255));
            if (i < COVER) crc = crc16_step(crc, fb[i]);
        end
        fb[FRAME-2] = crc[15:8];
        fb[FRAME-1] = crc[7:0];
        if (corrupt) fb[$urandom_range(FRAME - 1)] ^= 8'(1 << $urandom_range(7));
        for (int i = 0; i < len; i++) begin
            rx_bytes.push_back('{fb[i], (i == 0) ? sof : 1'b0});
        end
        items_queued += len;
    endtask

    task automatic run_phase(input int gap, input int stall, input int n_items, input bit squeeze);
        int added;
        int roll;
        int len;
        added     = 0;
        gap_pct   = gap;
        stall_pct = stall;
        while (added < n_items) begin
            roll = $urandom_range(99);
            if (roll < 76) begin
                queue_frame(FRAME, need_sof | ($urandom_range(1) == 1), $urandom_range(3) == 0);
                need_sof = 1'b0;
                added += FRAME;
            end else if (roll < 89) begin
                // truncated frame, next one must resync
                len = $urandom_range(1, FRAME - 1);
                queue_frame(len, 1'b1, 1'b0);
                need_sof = 1'b1;
                added += len;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    rx_bytes.push_back('{8'($urandom_range(255)), $urandom_range(3) == 0});
                end
                items_queued += len;
                need_sof = 1'b1;
                added += len;
            end
        end
        if (squeeze) begin
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold = 1'b0;
        end
        while (rx_bytes.size() != 0 || in_if.valid || echo_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.data_byte   = 8'h00;
        in_if.frame_start = 1'b0;
        out_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // abandoned start, all-ones bytes, then a restart mid-frame into a good frame
        for (int i = 0; i < 4; i++) rx_bytes.push_back('{8'hFF, 1'b0});
        rx_bytes.push_back('{8'h00, 1'b1});
        for (int i = 1; i < FRAME - 2; i++) begin
            rx_bytes.push_back('{(i % 2 == 0) ? 8'hFF : 8'h00, 1'b0});
        end
        begin : directed_trailer
            logic [15:0] crc;
            crc = CRC_INIT;
            for (int i = 0; i < COVER; i++) crc = crc16_step(crc, rx_bytes[4 + i].data);
            rx_bytes.push_back('{crc[15:8], 1'b0});
            rx_bytes.push_back('{crc[7:0], 1'b0});
        end
        items_queued += 4 + FRAME;

        run_phase(0, 0, 130, 1'b0);
        run_phase(46, 0, 140, 1'b0);
        run_phase(0, 46, 140, 1'b0);
        run_phase(31, 31, 140, 1'b0);
        run_phase(0, 0, 130, 1'b1);

        repeat (12) @(posedge i_clk);
        if (echo_due.size() != 0) begin
            errors++;
            $display("%0t ns: %0d predicted echoes never arrived", $time, echo_due.size());
        end
        $display("Sent %0d bytes, checked %0d echoes across five idle/stall mixes plus a long hold.",
                 items_queued, beats_seen);
        $display("Frame ends seen: %0d with matching CRC, %0d with mismatched CRC.",
                 frames_good, frames_bad);
        if (errors == 0) begin
            $display("frame_crc_checker test passed");
        end else begin
            $display("frame_crc_checker test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("frame_crc_checker test failed");
        $finish;
    end

    // driver: new beat only once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (rx_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
                t_rx_beat nb;
                nb = rx_bytes.pop_front();
                in_if.valid       <= 1'b1;
                in_if.data_byte   <= nb.data;
                in_if.frame_start <= nb.sof;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // predict on input beats, check on output beats
    always @(posedge i_clk) begin : monitor
        t_result want;
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            echo_due.push_back(predict_echo(in_if.data_byte, in_if.frame_start));
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            beats_seen++;
            if (echo_due.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected beat, expected none, got byte 0x%0h index %0d",
                         $time, out_if.byte_out, out_if.byte_index);
            end else begin
                want = echo_due.pop_front();
                check_field("byte_out", want.byte_out, out_if.byte_out);
                check_field("byte_index", want.byte_index, out_if.byte_index);
                check_field("frame_end", want.frame_end, out_if.frame_end);
                check_field("crc_ok", want.crc_ok, out_if.crc_ok);
                if (want.frame_end) begin
                    if (want.crc_ok) frames_good++;
                    else frames_bad++;
                end
            end
        end
    end

endmodule
